### rtl/cbf_pkg.sv
`timescale 1ns / 1ps

package cbf_pkg;

  // Stream and coefficient widths fixed by the register map.
  localparam int SAMPLE_W     = 16;
  localparam int COEF_W       = 32;
  localparam int FF_W         = 21;
  localparam int FF_PACK_W    = 3 * FF_W;
  localparam int REG_SECTIONS = 3;
  localparam int SC_W         = 2;

  // Fraction bits of the feedback and feedforward coefficients.
  localparam int FB_SHIFT = 30;
  localparam int FF_SHIFT = 18;

  // Configuration port.
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_STAGE_COUNT = 3'd0;
  localparam int CFG_FF_BASE = 1;
  localparam int CFG_FB_BASE = 2;

  // Control word from the sequencer to the shared multiply-accumulate unit.
  typedef struct packed {
    logic issue;  // start a partial product this cycle
    logic hi;     // use the upper half of the state operand
    logic neg;    // subtract the product instead of adding it
    logic load;   // overwrite the accumulator with the load value
  } mac_ctrl_t;

endpackage

### rtl/cbf_mac.sv
`timescale 1ns / 1ps

module cbf_mac import cbf_pkg::*; #(
  parameter int STATE_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  mac_ctrl_t                               ctrl,
  input  logic signed [COEF_W-1:0]                coef,
  input  logic signed [STATE_WIDTH-1:0]           operand,
  input  logic signed [STATE_WIDTH+COEF_W+1:0]    load_value,
  output logic signed [STATE_WIDTH+COEF_W+1:0]    acc
);

  localparam int ACC_W  = STATE_WIDTH + COEF_W + 2;
  localparam int LO_W   = STATE_WIDTH / 2;
  localparam int HI_W   = STATE_WIDTH - LO_W;
  localparam int MUL_W  = HI_W + 1;
  localparam int PROD_W = COEF_W + MUL_W;

  logic signed [MUL_W-1:0]  chunk;
  logic signed [PROD_W-1:0] prod;
  logic                     p_valid;
  logic                     p_hi;
  logic                     p_neg;
  logic signed [ACC_W-1:0]  term;

  // The state word is multiplied in two halves: the low half unsigned,
  // the high half signed and weighted by 2^LO_W when accumulated.
  always_comb begin
    if (ctrl.hi) begin
      chunk = {operand[STATE_WIDTH-1], operand[STATE_WIDTH-1:LO_W]};
    end else begin
      chunk = {{(MUL_W-LO_W){1'b0}}, operand[LO_W-1:0]};
    end
  end

  always_comb begin
    term = ACC_W'(prod);
    if (p_hi) begin
      term = term <<< LO_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= ctrl.issue;
    end
  end

  always_ff @(posedge clk) begin
    prod  <= coef * chunk;
    p_hi  <= ctrl.hi;
    p_neg <= ctrl.neg;
    if (ctrl.load) begin
      acc <= load_value;
    end else if (p_valid) begin
      acc <= p_neg ? acc - term : acc + term;
    end
  end

endmodule

### rtl/cascaded_biquad_filter_unit.sv
`timescale 1ns / 1ps
// Each sample runs through the active sections in turn (straight to the output
// register with zero stages); a new sample is accepted only after the previous
// result has gone to the output register. Each section runs ten half-width
// partial products through the one shared multiplier.
// Reset (rst, synchronous, active high) clears the sequencer, the output valid, the
// configuration registers and the filter history.
module cascaded_biquad_filter_unit import cbf_pkg::*; #(
  parameter int MAX_STAGES  = 3,
  parameter int STATE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] sample_in
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [SAMPLE_W-1:0]    m_axis_tdata    // [15:0] sample_out
);

  // Accumulator width covers x*2^30 minus two 32-bit by state-width products.
  localparam int ACC_W     = STATE_WIDTH + COEF_W + 2;
  // Input samples enter the state format shifted up by this many bits.
  localparam int IN_SHIFT  = STATE_WIDTH - 20;
  localparam int SEC_W     = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int STEP_BITS = 4;
  localparam int W_TOP     = ACC_W - FB_SHIFT - STATE_WIDTH + 1;
  localparam int Y_TOP     = ACC_W - FF_SHIFT - STATE_WIDTH + 1;
  localparam int Q_W       = STATE_WIDTH - IN_SHIFT;

  // Sequencer steps inside one section. Products are issued in pairs
  // (low half, then high half of the state word), and the accumulator
  // picks each one up from a product register.
  localparam logic [STEP_BITS-1:0] STEP_LOAD = 4'd0;
  localparam logic [STEP_BITS-1:0] STEP_W    = 4'd5;
  localparam logic [STEP_BITS-1:0] STEP_Y    = 4'd13;

  localparam logic [STEP_BITS-2:0] PAIR_A1 = 3'd0;
  localparam logic [STEP_BITS-2:0] PAIR_A2 = 3'd1;
  localparam logic [STEP_BITS-2:0] PAIR_B0 = 3'd3;
  localparam logic [STEP_BITS-2:0] PAIR_B1 = 3'd4;
  localparam logic [STEP_BITS-2:0] PAIR_B2 = 3'd5;

  localparam logic signed [STATE_WIDTH-1:0] STATE_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [STATE_WIDTH-1:0] STATE_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [SC_W-1:0]      stage_count;
  logic [FF_PACK_W-1:0] ff_reg [REG_SECTIONS];
  logic [COEF_W*2-1:0]  fb_reg [REG_SECTIONS];

  // Delay pair of every section: w1 is the newest value, w2 the one before.
  logic signed [STATE_WIDTH-1:0] w1_hist [MAX_STAGES];
  logic signed [STATE_WIDTH-1:0] w2_hist [MAX_STAGES];

  logic [STEP_BITS-1:0]          step;
  logic [SEC_W-1:0]              sec;
  logic signed [STATE_WIDTH-1:0] x_reg;
  logic signed [STATE_WIDTH-1:0] w_reg;

  logic [SC_W-1:0]               n_eff;
  logic                          s_fire;
  logic [STEP_BITS-2:0]          pair;
  logic signed [STATE_WIDTH-1:0] w1_cur;
  logic signed [STATE_WIDTH-1:0] w2_cur;
  logic signed [COEF_W-1:0]      a1_c;
  logic signed [COEF_W-1:0]      a2_c;
  logic signed [COEF_W-1:0]      b0_c;
  logic signed [COEF_W-1:0]      b1_c;
  logic signed [COEF_W-1:0]      b2_c;
  logic signed [COEF_W-1:0]      coef;
  logic signed [STATE_WIDTH-1:0] operand;
  logic signed [ACC_W-1:0]       load_value;
  logic signed [ACC_W-1:0]       acc;
  mac_ctrl_t                     ctrl;

  logic [W_TOP-1:0]              w_guard;
  logic [Y_TOP-1:0]              y_guard;
  logic signed [STATE_WIDTH-1:0] w_sat;
  logic signed [STATE_WIDTH-1:0] y_sat;
  logic signed [STATE_WIDTH-1:0] y_adj;
  logic [Q_W-1:0]                q_full;
  logic [SAMPLE_W-1:0]           q_sat;

  // A stage count above the number of built sections is clamped.
  assign n_eff  = (stage_count > SC_W'(MAX_STAGES)) ? SC_W'(MAX_STAGES) : stage_count;
  assign s_axis_tready = (state == IDLE);
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // Configuration writes. Index values past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_count <= '0;
      for (int i = 0; i < REG_SECTIONS; i++) begin
        ff_reg[i] <= '0;
        fb_reg[i] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == CFG_STAGE_COUNT) begin
        stage_count <= cfg_data[SC_W-1:0];
      end
      for (int i = 0; i < REG_SECTIONS; i++) begin
        if (cfg_index == CFG_INDEX_W'(CFG_FF_BASE + 2 * i)) begin
          ff_reg[i] <= cfg_data[FF_PACK_W-1:0];
        end
        if (cfg_index == CFG_INDEX_W'(CFG_FB_BASE + 2 * i)) begin
          fb_reg[i] <= cfg_data;
        end
      end
    end
  end

  // Coefficients and history of the section being worked on.
  assign w1_cur = w1_hist[sec];
  assign w2_cur = w2_hist[sec];
  assign a1_c   = fb_reg[sec][COEF_W-1:0];
  assign a2_c   = fb_reg[sec][2*COEF_W-1:COEF_W];
  assign b0_c   = COEF_W'(signed'(ff_reg[sec][FF_W-1:0]));
  assign b1_c   = COEF_W'(signed'(ff_reg[sec][2*FF_W-1:FF_W]));
  assign b2_c   = COEF_W'(signed'(ff_reg[sec][3*FF_W-1:2*FF_W]));

  assign pair = step[STEP_BITS-1:1];

  // Operand selection for the shared multiplier. The feedback pairs come
  // first and are subtracted; the b0 pair uses the new w.
  always_comb begin
    coef      = '0;
    operand   = w_reg;
    ctrl      = '0;
    ctrl.hi   = step[0];
    ctrl.neg  = (pair == PAIR_A1) || (pair == PAIR_A2);
    case (pair)
      PAIR_A1: begin
        coef = a1_c;
        operand = w1_cur;
        ctrl.issue = (state == RUN);
      end
      PAIR_A2: begin
        coef = a2_c;
        operand = w2_cur;
        ctrl.issue = (state == RUN);
      end
      PAIR_B0: begin
        coef = b0_c;
        operand = w_reg;
        ctrl.issue = (state == RUN);
      end
      PAIR_B1: begin
        coef = b1_c;
        operand = w1_cur;
        ctrl.issue = (state == RUN);
      end
      PAIR_B2: begin
        coef = b2_c;
        operand = w2_cur;
        ctrl.issue = (state == RUN);
      end
      default: begin
        ctrl.issue = 1'b0;
      end
    endcase
    ctrl.load = (state == RUN) && ((step == STEP_LOAD) || (step == STEP_W));
    if (step == STEP_LOAD) begin
      // Section input x scaled by 2^30, the weight of the feedback products.
      load_value = {{(ACC_W-FB_SHIFT-STATE_WIDTH){x_reg[STATE_WIDTH-1]}}, x_reg,
                    {FB_SHIFT{1'b0}}};
    end else begin
      load_value = '0;
    end
  end

  cbf_mac #(
    .STATE_WIDTH(STATE_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .coef      (coef),
    .operand   (operand),
    .load_value(load_value),
    .acc       (acc)
  );

  // Floor shift and saturation of the accumulator: the dropped top bits
  // must all equal the new sign bit, otherwise the result clips.
  assign w_guard = acc[ACC_W-1:FB_SHIFT+STATE_WIDTH-1];
  assign y_guard = acc[ACC_W-1:FF_SHIFT+STATE_WIDTH-1];

  always_comb begin
    if ((&w_guard) || !(|w_guard)) begin
      w_sat = acc[FB_SHIFT+STATE_WIDTH-1:FB_SHIFT];
    end else begin
      w_sat = acc[ACC_W-1] ? STATE_MIN : STATE_MAX;
    end
    if ((&y_guard) || !(|y_guard)) begin
      y_sat = acc[FF_SHIFT+STATE_WIDTH-1:FF_SHIFT];
    end else begin
      y_sat = acc[ACC_W-1] ? STATE_MIN : STATE_MAX;
    end
  end

  // Back to 16 bits: negative values get the shifted-out bits added first,
  // so the arithmetic shift truncates toward zero. With zero stages x_reg
  // still holds the scaled sample, which this path returns unchanged.
  assign y_adj  = x_reg + {{(STATE_WIDTH-IN_SHIFT){1'b0}}, {IN_SHIFT{x_reg[STATE_WIDTH-1]}}};
  assign q_full = y_adj[STATE_WIDTH-1:IN_SHIFT];

  always_comb begin
    if ((&q_full[Q_W-1:SAMPLE_W-1]) || !(|q_full[Q_W-1:SAMPLE_W-1])) begin
      q_sat = q_full[SAMPLE_W-1:0];
    end else begin
      q_sat = q_full[Q_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // Delay pairs shift once per section, at the end of its pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_STAGES; i++) begin
        w1_hist[i] <= '0;
        w2_hist[i] <= '0;
      end
    end else if ((state == RUN) && (step == STEP_Y)) begin
      w1_hist[sec] <= w_reg;
      w2_hist[sec] <= w1_cur;
    end
  end

  // Sequencer: one section after another, then the result waits in the
  // output register. A new sample is taken only in IDLE, which is reached
  // as soon as the result is handed to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      step          <= '0;
      sec           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // In OUT a finished transfer is replaced by the next result below.
      if (m_axis_tvalid && m_axis_tready && (state != OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_fire) begin
            x_reg <= {{4{s_axis_tdata[SAMPLE_W-1]}}, s_axis_tdata, {IN_SHIFT{1'b0}}};
            step  <= STEP_LOAD;
            sec   <= '0;
            state <= (n_eff == '0) ? OUT : RUN;
          end
        end
        RUN: begin
          if (step == STEP_W) begin
            w_reg <= w_sat;
          end
          if (step == STEP_Y) begin
            x_reg <= y_sat;
            step  <= STEP_LOAD;
            if (SC_W'(sec) == n_eff - SC_W'(1)) begin
              state <= OUT;
            end else begin
              sec <= sec + 1'b1;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= q_sat;
            m_axis_tvalid <= 1'b1;
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_start: assert property (@(posedge clk) disable iff (rst)
    s_fire && (n_eff != '0) |=> (state == RUN) && (step == STEP_LOAD) && (sec == '0))
    else $error("filter pass did not start at the first section");

  a_bypass: assert property (@(posedge clk) disable iff (rst)
    s_fire && (n_eff == '0) |=> (state == OUT))
    else $error("zero stage sample did not go straight to the output");

  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    (state == RUN) |-> (SC_W'(sec) < n_eff) && (step <= STEP_Y))
    else $error("sequencer left the active sections");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == OUT) && m_axis_tvalid && !m_axis_tready |=> (state == OUT) && m_axis_tvalid)
    else $error("result overwrote a pending output transfer");
`endif

endmodule
